FILE: src/lbm_pkg.sv
// Shared types and constants of the latency byte memory.
// Holds operation, phase and task codes and the structs passed between blocks.
// No dependencies.
package lbm_pkg;

	// Payload widths fixed by the item fields.
	localparam int OP_W    = 3;
	localparam int ADDR_W  = 8;
	localparam int CNT_W   = 4;
	localparam int DATA_W  = 64;
	localparam int TICK_W  = 4;
	localparam int PHASE_W = 2;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_FETCH  = 3'd0;
	localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd2;
	localparam logic [OP_W-1:0] OP_WORK   = 3'd3;
	localparam logic [OP_W-1:0] OP_EFETCH = 3'd4;
	localparam logic [OP_W-1:0] OP_ESTORE = 3'd5;
	localparam logic [OP_W-1:0] OP_HWRITE = 3'd6;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd7;

	// Phase codes as shown on the result.
	localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
	localparam logic [PHASE_W-1:0] PH_WAIT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_MOVE = 2'd2;

	// Pending task codes.
	localparam logic [1:0] TASK_NONE  = 2'd0;
	localparam logic [1:0] TASK_FETCH = 2'd1;
	localparam logic [1:0] TASK_STORE = 2'd2;

	// Tick thresholds.
	localparam logic [TICK_W-1:0] WAIT_FORCE   = 4'd7;
	localparam logic [TICK_W-1:0] TICK_MAX     = 4'd15;
	localparam logic [TICK_W-1:0] WAIT_RST_VAL = 4'd4;

	// Command from the sequencer to the phase controller.
	typedef struct packed {
		logic            apply;
		logic [OP_W-1:0] op;
	} lbm_cmd_t;

	// Flags and phase kept by the phase controller.
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               fetch_done;
		logic               store_done;
		logic               more_work;
	} lbm_status_t;

	// One byte access to the memory: a write or a read, never both.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} lbm_ram_req_t;

endpackage

FILE: src/lbm_if.sv
// Handshake channels of the latency byte memory: request, result and configuration.
// Depends on lbm_pkg for the payload widths.
interface lbm_req_if;
	import lbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] addr;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] write_bytes;
	modport source (output valid, op, addr, count, write_bytes, input ready);
	modport sink (input valid, op, addr, count, write_bytes, output ready);
endinterface

interface lbm_rsp_if;
	import lbm_pkg::*;
	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  read_bytes;
	logic               fetch_done;
	logic               store_done;
	logic               more_work;
	logic [PHASE_W-1:0] phase;
	modport source (output valid, read_bytes, fetch_done, store_done, more_work, phase,
		input ready);
	modport sink (input valid, read_bytes, fetch_done, store_done, more_work, phase,
		output ready);
endinterface

interface lbm_cfg_if;
	import lbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: src/lbm_byte_ram.sv
// Byte-wide synchronous memory with one access port and registered read data.
// Depends on lbm_pkg for the access request struct.
module lbm_byte_ram import lbm_pkg::*; #(
	parameter int MEM_BYTES = 256
) (
	input  logic         clk,
	input  lbm_ram_req_t req,
	output logic [7:0]   rdata
);
	localparam int AW = $clog2(MEM_BYTES);

	logic [7:0] mem [MEM_BYTES];
	logic [7:0] rdata_q;

	// Write or read one byte; read data is registered and appears in the cycle after the read.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr[AW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.addr[AW-1:0]];
		end
	end

	assign rdata = rdata_q;
endmodule

FILE: src/lbm_phase.sv
// Phase controller: phase, tick counter, pending task and completion flags.
// Depends on lbm_pkg for codes and the command and status structs.
module lbm_phase import lbm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  lbm_cmd_t          cmd,
	input  logic [TICK_W-1:0] wait_ticks,
	output lbm_status_t       status
);
	logic [PHASE_W-1:0] phase_q;
	logic [TICK_W-1:0]  tick_q;
	logic [1:0]         task_q;
	logic               fetch_done_q;
	logic               store_done_q;
	logic               more_work_q;
	logic [TICK_W-1:0]  tick_inc;

	// Saturating tick increment.
	assign tick_inc = (tick_q == TICK_MAX) ? tick_q : tick_q + 4'd1;

	// Apply each accepted item to the control state in its accept cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			task_q       <= TASK_NONE;
			fetch_done_q <= 1'b0;
			store_done_q <= 1'b0;
			more_work_q  <= 1'b0;
		end else if (cmd.apply) begin
			case (cmd.op)
				OP_FETCH, OP_STORE: begin
					task_q       <= (cmd.op == OP_FETCH) ? TASK_FETCH : TASK_STORE;
					fetch_done_q <= 1'b0;
					store_done_q <= 1'b0;
					more_work_q  <= 1'b1;
					phase_q      <= PH_WAIT;
				end
				OP_TICK: begin
					more_work_q <= 1'b1;
					if (phase_q == PH_WAIT) begin
						if (tick_inc >= wait_ticks) begin
							tick_q  <= '0;
							phase_q <= PH_MOVE;
						end else begin
							tick_q <= tick_inc;
						end
					end
				end
				OP_WORK: begin
					if (phase_q == PH_IDLE) begin
						more_work_q <= 1'b0;
					end else if (phase_q == PH_WAIT) begin
						if (tick_q >= WAIT_FORCE) begin
							phase_q <= PH_MOVE;
						end else begin
							more_work_q <= 1'b0;
						end
					end else begin
						if (task_q == TASK_FETCH) begin
							fetch_done_q <= 1'b1;
						end else if (task_q == TASK_STORE) begin
							store_done_q <= 1'b1;
						end
						more_work_q <= 1'b0;
						phase_q     <= PH_IDLE;
					end
				end
				OP_EFETCH: begin
					fetch_done_q <= 1'b0;
				end
				OP_ESTORE: begin
					store_done_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign status.phase      = phase_q;
	assign status.fetch_done = fetch_done_q;
	assign status.store_done = store_done_q;
	assign status.more_work  = more_work_q;
endmodule

FILE: src/lbm_seq.sv
// Access sequencer: takes request beats, walks bursts and clears over the byte memory,
// and holds the fetch and store buffers. Depends on lbm_pkg and lbm_if.
module lbm_seq import lbm_pkg::*; #(
	parameter int MEM_BYTES   = 256,
	parameter int BURST_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	lbm_req_if.sink           req,
	input  logic              out_free,
	input  logic [7:0]        ram_rdata,
	output lbm_ram_req_t      ram_req,
	output lbm_cmd_t          cmd,
	output logic              fin,
	output logic [DATA_W-1:0] fetch_flat
);
	localparam int AW  = $clog2(MEM_BYTES);
	localparam int BIW = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
	localparam logic [CNT_W-1:0]  BurstCnt = CNT_W'(BURST_BYTES);
	localparam logic [ADDR_W:0]   MemSize  = (ADDR_W+1)'(MEM_BYTES);
	localparam logic [AW-1:0]     LastAddr = AW'(MEM_BYTES - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ADDR   = 5'b00010,
		S_RUN    = 5'b00100,
		S_CLEAR  = 5'b01000,
		S_FINISH = 5'b10000
	} seq_state_t;

	seq_state_t        state_q;
	logic [OP_W-1:0]   op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [AW-1:0]     ptr_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [AW-1:0]     store_addr_q;
	logic [7:0]        store_buf_q [BURST_BYTES];
	logic [7:0]        fetch_buf_q [BURST_BYTES];
	logic              rd_valid_s1;
	logic [BIW-1:0]    rd_idx_s1;

	logic              accept;
	logic [CNT_W-1:0]  cnt_cap;
	logic              active;
	logic              is_fetch;
	logic [AW-1:0]     ptr_next;
	logic [7:0]        wr_byte;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cnt_cap   = (req.count > BurstCnt) ? BurstCnt : req.count;
	assign active    = (idx_q < n_q);
	assign is_fetch  = (op_q == OP_FETCH);
	assign ptr_next  = (ptr_q == LastAddr) ? '0 : ptr_q + 1'b1;
	assign wr_byte   = (op_q == OP_HWRITE) ? data_q[{idx_q[2:0], 3'b000} +: 8]
		: store_buf_q[idx_q[BIW-1:0]];

	assign cmd.apply = accept;
	assign cmd.op    = req.op;
	assign fin       = (state_q == S_FINISH) && out_free;

	// Memory access of the current cycle.
	always_comb begin
		ram_req       = '0;
		ram_req.addr  = ADDR_W'(ptr_q);
		ram_req.wdata = wr_byte;
		if (state_q == S_RUN && active) begin
			ram_req.we = !is_fetch;
			ram_req.re = is_fetch;
		end else if (state_q == S_CLEAR) begin
			ram_req.we    = 1'b1;
			ram_req.wdata = 8'h00;
		end
	end

	// Sequencer state and burst counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_TICK;
			addr_q       <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			ptr_q        <= '0;
			byte_count_q <= '0;
			store_addr_q <= '0;
			rd_valid_s1  <= 1'b0;
			for (int i = 0; i < BURST_BYTES; i++) begin
				store_buf_q[i] <= 8'h00;
			end
		end else begin
			rd_valid_s1 <= (state_q == S_RUN) && active && is_fetch;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= req.op;
						addr_q <= req.addr;
						idx_q  <= '0;
						case (req.op)
							OP_FETCH, OP_HWRITE: begin
								n_q     <= cnt_cap;
								state_q <= S_ADDR;
								if (req.op == OP_FETCH) begin
									byte_count_q <= cnt_cap;
								end
							end
							OP_STORE: begin
								byte_count_q <= cnt_cap;
								n_q          <= cnt_cap;
								state_q      <= S_ADDR;
								for (int i = 0; i < BURST_BYTES; i++) begin
									if (CNT_W'(i) < cnt_cap) begin
										store_buf_q[i] <= req.write_bytes[8*i +: 8];
									end
								end
							end
							OP_ESTORE: begin
								n_q     <= byte_count_q;
								ptr_q   <= store_addr_q;
								state_q <= S_RUN;
							end
							OP_CLEAR: begin
								ptr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_ADDR: begin
					// Reduce the start address below the memory size.
					if ({1'b0, addr_q} >= MemSize) begin
						addr_q <= ADDR_W'({1'b0, addr_q} - MemSize);
					end else begin
						ptr_q <= addr_q[AW-1:0];
						if (op_q == OP_STORE) begin
							store_addr_q <= addr_q[AW-1:0];
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					// One byte a cycle; the last fetch read lands before leaving.
					if (active) begin
						idx_q <= idx_q + 1'b1;
						ptr_q <= ptr_next;
					end else if (!rd_valid_s1) begin
						state_q <= S_FINISH;
					end
				end
				S_CLEAR: begin
					if (ptr_q == LastAddr) begin
						state_q <= S_FINISH;
					end else begin
						ptr_q <= ptr_next;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Data of the accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= req.write_bytes;
		end
	end

	// Read index is registered and follows the read request in the cycle after it.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[BIW-1:0];
	end

	// Fetch buffer takes each returned byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BURST_BYTES; i++) begin
				fetch_buf_q[i] <= 8'h00;
			end
		end else if (rd_valid_s1) begin
			fetch_buf_q[rd_idx_s1] <= ram_rdata;
		end
	end

	// Fetch buffer as a flat word; bytes past the burst read as zero.
	always_comb begin
		fetch_flat = '0;
		for (int i = 0; i < BURST_BYTES; i++) begin
			fetch_flat[8*i +: 8] = fetch_buf_q[i];
		end
	end
endmodule

FILE: src/latency_byte_memory_core.sv
// Latency byte memory top level: configuration register, result register and block wiring.
// Depends on lbm_pkg, lbm_if, lbm_byte_ram, lbm_phase and lbm_seq.
//
// The block takes one request beat at a time and returns exactly one result beat for it.
// Tick, cycle-work and end-fetch items go straight to the finish step. The byte
// memory has one port and is accessed one byte a cycle, so a burst walks its bytes
// one at a time. Host write, fetch and start store first reduce the start address by
// compare-and-subtract steps, addr / MEM_BYTES of them (none for a 256-byte memory).
// Clear walks every entry. A new request is taken while the previous result still
// waits in the output register. Memory bytes that were never written or cleared read
// back as unknown data.
module latency_byte_memory_core import lbm_pkg::*; #(
	parameter int MEM_BYTES   = 256,
	parameter int BURST_BYTES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	lbm_req_if.sink   req,
	lbm_rsp_if.source rsp,
	lbm_cfg_if.sink   cfg
);
	logic [TICK_W-1:0]  wait_ticks_q;
	logic               rsp_valid_q;
	logic [DATA_W-1:0]  read_bytes_q;
	logic               fetch_done_q;
	logic               store_done_q;
	logic               more_work_q;
	logic [PHASE_W-1:0] phase_q;

	lbm_ram_req_t       ram_req;
	logic [7:0]         ram_rdata;
	lbm_cmd_t           cmd;
	lbm_status_t        status;
	logic               fin;
	logic               out_free;
	logic [DATA_W-1:0]  fetch_flat;

	// Configuration beats are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_ticks_q <= WAIT_RST_VAL;
		end else if (cfg.valid) begin
			wait_ticks_q <= cfg.data;
		end
	end

	lbm_seq #(
		.MEM_BYTES  (MEM_BYTES),
		.BURST_BYTES(BURST_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_free  (out_free),
		.ram_rdata (ram_rdata),
		.ram_req   (ram_req),
		.cmd       (cmd),
		.fin       (fin),
		.fetch_flat(fetch_flat)
	);

	lbm_byte_ram #(
		.MEM_BYTES(MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.req  (ram_req),
		.rdata(ram_rdata)
	);

	lbm_phase u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wait_ticks(wait_ticks_q),
		.status    (status)
	);

	// Result register; a finished item loads it once the slot is free.
	assign out_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			read_bytes_q <= fetch_flat;
			fetch_done_q <= status.fetch_done;
			store_done_q <= status.store_done;
			more_work_q  <= status.more_work;
			phase_q      <= status.phase;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_bytes = read_bytes_q;
	assign rsp.fetch_done = fetch_done_q;
	assign rsp.store_done = store_done_q;
	assign rsp.more_work  = more_work_q;
	assign rsp.phase      = phase_q;
endmodule

FILE: src/lbm_checker.sv
// Port-level checks of the latency byte memory, attached to the top level by bind.
// Depends on lbm_pkg for codes and widths.
module lbm_port_checker import lbm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [DATA_W-1:0]  read_bytes,
	input logic               fetch_done,
	input logic               store_done,
	input logic [PHASE_W-1:0] phase
);
	logic [1:0] outstanding_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	// Items accepted whose result beat has not yet gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (in_beat && !out_beat) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (out_beat && !in_beat) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	// A stalled result beat holds its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_bytes) && $stable(phase))
		else $error("result beat changed while stalled");

	// No result without an accepted item, and at most one item behind the result.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 2'd0)
		else $error("result beat without an accepted item");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q != 2'd3)
		else $error("too many items in flight");

	// Completion flags are only up while the block is idle, and never both.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fetch_done && store_done)
			&& (phase == PH_IDLE || (!fetch_done && !store_done)))
		else $error("completion flag outside idle phase");

	// The phase code stays within idle, waiting and move-data.
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> phase != 2'd3)
		else $error("undefined phase code");
endmodule

bind latency_byte_memory_core lbm_port_checker u_lbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.read_bytes(rsp.read_bytes),
	.fetch_done(rsp.fetch_done),
	.store_done(rsp.store_done),
	.phase     (rsp.phase)
);
